[rtl/cubic_definite_integrator_top_macros.svh]
`ifndef CUBIC_DEFINITE_INTEGRATOR_TOP_MACROS_SVH
`define CUBIC_DEFINITE_INTEGRATOR_TOP_MACROS_SVH

// a implies b in the same cycle
`define CDI_ASSERT_IMP(lbl, clk, rst_n, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("assertion failed");

// a implies b in the next cycle
`define CDI_ASSERT_NXT(lbl, clk, rst_n, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("assertion failed");

`endif

[rtl/cdi_pkg.sv]
`default_nettype none
package cdi_pkg;

  localparam int IN_W   = 24;
  localparam int CNT_W  = 16;
  localparam int D_W    = 17;
  localparam int OUT_W  = 48;
  localparam int ST_W   = 2;
  localparam int QW     = 57;
  localparam int ACC_W  = 64;
  localparam int F_W    = 42;
  localparam int MAX_INTERVALS_DEF = 65535;

  localparam logic [ST_W-1:0] STATUS_OK   = 2'd0;
  localparam logic [ST_W-1:0] STATUS_SAT  = 2'd1;
  localparam logic [ST_W-1:0] STATUS_ZERO = 2'd2;

  localparam logic OP_SIMPSON = 1'b0;
  localparam logic OP_TRAP    = 1'b1;

  localparam logic [OUT_W-1:0] VAL_MAX = 48'h7FFF_FFFF_FFFF;
  localparam logic [OUT_W-1:0] VAL_MIN = 48'h8000_0000_0000;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PREP,
    ST_DIVS,
    ST_SAMPLE,
    ST_DRAIN,
    ST_MAG,
    ST_MULH,
    ST_MULL,
    ST_QSTART,
    ST_DIVQ,
    ST_FIN
  } cdi_state_t;

  typedef struct packed {
    logic load;
    logic div_start;
    logic div_sel_q;
    logic take_step;
    logic issue;
    logic take_mag;
    logic mul_hi;
    logic mul_lo;
    logic load_out;
  } cdi_cmd_t;

  typedef struct packed {
    logic cnt_zero;
    logic div_done;
    logic last_point;
    logic pipe_empty;
    logic out_free;
  } cdi_sts_t;

endpackage
`default_nettype wire

[rtl/cubic_definite_integrator_top.sv]
// channel | ports                                                    | dir
// in      | in_valid in_stall in_opcode in_lower_bound in_upper_bound | in
//         | in_interval_count                                        |
// out     | out_valid out_stall out_integral_value out_status        | out
//
// one word at a time, Simpson or trapezoid
// the sample loop issues one cubic evaluation per cycle into a 3 stage pipeline
// the step comes from the bit-serial divider, then the sum is divided by 2 or 3
// a zero count skips to the result; rst_n is synchronous and clears all control
// the next word is taken while a result waits on out_stall
`default_nettype none
module cubic_definite_integrator_top #(
  parameter int MAX_INTERVALS = cdi_pkg::MAX_INTERVALS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic                              in_opcode,
  input  wire logic signed [cdi_pkg::IN_W-1:0]   in_lower_bound,
  input  wire logic signed [cdi_pkg::IN_W-1:0]   in_upper_bound,
  input  wire logic        [cdi_pkg::CNT_W-1:0]  in_interval_count,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic signed      [cdi_pkg::OUT_W-1:0]  out_integral_value,
  output logic             [cdi_pkg::ST_W-1:0]   out_status
);

  cdi_pkg::cdi_cmd_t cmd;
  cdi_pkg::cdi_sts_t sts;

  cdi_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  cdi_dp #(
    .MAX_INTERVALS (MAX_INTERVALS)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .in_opcode          (in_opcode),
    .in_lower_bound     (in_lower_bound),
    .in_upper_bound     (in_upper_bound),
    .in_interval_count  (in_interval_count),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_integral_value (out_integral_value),
    .out_status         (out_status)
  );

endmodule
`default_nettype wire

[rtl/cdi_div.sv]
`default_nettype none
module cdi_div (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  input  wire logic [cdi_pkg::QW-1:0]     dividend,
  input  wire logic [cdi_pkg::D_W-1:0]    divisor,
  output logic      [cdi_pkg::QW-1:0]     quotient,
  output logic                            done
);

  localparam int CW = $clog2(cdi_pkg::QW);
  localparam logic [CW-1:0] CNT_LAST = CW'(cdi_pkg::QW - 1);

  logic [cdi_pkg::QW-1:0]  quo_r;
  logic [cdi_pkg::D_W-1:0] rem_r;
  logic [cdi_pkg::D_W-1:0] dvs_r;
  logic [CW-1:0]           cnt_r;
  logic                    busy_r;
  logic                    done_r;
  logic [cdi_pkg::D_W:0]   trial;
  logic [cdi_pkg::D_W:0]   diffv;
  logic                    ge;

  assign trial = {rem_r, quo_r[cdi_pkg::QW-1]};
  assign ge    = trial >= {1'b0, dvs_r};
  assign diffv = trial - {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_LAST) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      rem_r <= ge ? diffv[cdi_pkg::D_W-1:0] : trial[cdi_pkg::D_W-1:0];
      quo_r <= {quo_r[cdi_pkg::QW-2:0], ge};
    end
  end

  assign quotient = quo_r;
  assign done     = done_r;

endmodule
`default_nettype wire

[rtl/cdi_ctrl.sv]
`default_nettype none
`include "cubic_definite_integrator_top_macros.svh"
module cdi_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire cdi_pkg::cdi_sts_t sts,
  output cdi_pkg::cdi_cmd_t      cmd
);

  cdi_pkg::cdi_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= cdi_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      cdi_pkg::ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = cdi_pkg::ST_PREP;
        end
      end
      cdi_pkg::ST_PREP: begin
        if (sts.cnt_zero) begin
          state_nxt = cdi_pkg::ST_FIN;
        end else begin
          cmd.div_start = 1'b1;
          state_nxt     = cdi_pkg::ST_DIVS;
        end
      end
      cdi_pkg::ST_DIVS: begin
        if (sts.div_done) begin
          cmd.take_step = 1'b1;
          state_nxt     = cdi_pkg::ST_SAMPLE;
        end
      end
      cdi_pkg::ST_SAMPLE: begin
        cmd.issue = 1'b1;
        if (sts.last_point) begin
          state_nxt = cdi_pkg::ST_DRAIN;
        end
      end
      cdi_pkg::ST_DRAIN: begin
        if (sts.pipe_empty) begin
          state_nxt = cdi_pkg::ST_MAG;
        end
      end
      cdi_pkg::ST_MAG: begin
        cmd.take_mag = 1'b1;
        state_nxt    = cdi_pkg::ST_MULH;
      end
      cdi_pkg::ST_MULH: begin
        cmd.mul_hi = 1'b1;
        state_nxt  = cdi_pkg::ST_MULL;
      end
      cdi_pkg::ST_MULL: begin
        cmd.mul_lo = 1'b1;
        state_nxt  = cdi_pkg::ST_QSTART;
      end
      cdi_pkg::ST_QSTART: begin
        cmd.div_start = 1'b1;
        cmd.div_sel_q = 1'b1;
        state_nxt     = cdi_pkg::ST_DIVQ;
      end
      cdi_pkg::ST_DIVQ: begin
        cmd.div_sel_q = 1'b1;
        if (sts.div_done) begin
          state_nxt = cdi_pkg::ST_FIN;
        end
      end
      cdi_pkg::ST_FIN: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = cdi_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = cdi_pkg::ST_IDLE;
      end
    endcase
  end

  assign in_stall = (state_r != cdi_pkg::ST_IDLE);

  `CDI_ASSERT_IMP(a_done_when_waiting, clk, rst_n, sts.div_done, (state_r == cdi_pkg::ST_DIVS || state_r == cdi_pkg::ST_DIVQ))
  `CDI_ASSERT_NXT(a_issue_stays, clk, rst_n, cmd.issue, (state_r == cdi_pkg::ST_SAMPLE || state_r == cdi_pkg::ST_DRAIN))
  `CDI_ASSERT_NXT(a_drain_to_mag, clk, rst_n, (state_r == cdi_pkg::ST_DRAIN && sts.pipe_empty), (state_r == cdi_pkg::ST_MAG))
  `CDI_ASSERT_NXT(a_out_then_idle, clk, rst_n, cmd.load_out, (state_r == cdi_pkg::ST_IDLE && !in_stall))

endmodule
`default_nettype wire

[rtl/cdi_dp.sv]
`default_nettype none
module cdi_dp #(
  parameter int MAX_INTERVALS = cdi_pkg::MAX_INTERVALS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire cdi_pkg::cdi_cmd_t                 cmd,
  output cdi_pkg::cdi_sts_t                      sts,
  input  wire logic                              in_opcode,
  input  wire logic signed [cdi_pkg::IN_W-1:0]   in_lower_bound,
  input  wire logic signed [cdi_pkg::IN_W-1:0]   in_upper_bound,
  input  wire logic        [cdi_pkg::CNT_W-1:0]  in_interval_count,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic signed      [cdi_pkg::OUT_W-1:0]  out_integral_value,
  output logic             [cdi_pkg::ST_W-1:0]   out_status
);

  localparam int IW = cdi_pkg::IN_W;
  localparam int DW = cdi_pkg::D_W;
  localparam int QW = cdi_pkg::QW;
  localparam int AW = cdi_pkg::ACC_W;
  localparam int FW = cdi_pkg::F_W;
  localparam int OW = cdi_pkg::OUT_W;

  // request registers
  logic                 op_r;
  logic signed [IW-1:0] lo_r, hi_r;
  logic [IW-1:0]        diff_r;
  logic [DW-1:0]        d_r;
  logic                 zero_r;
  logic [IW-1:0]        step_r;

  logic signed [IW-1:0]    lo_s, hi_s;
  logic [IW:0]             diff_w;
  logic [cdi_pkg::CNT_W-1:0] n_cl;

  always_comb begin
    if (in_upper_bound < in_lower_bound) begin
      lo_s = in_upper_bound;
      hi_s = in_lower_bound;
    end else begin
      lo_s = in_lower_bound;
      hi_s = in_upper_bound;
    end
    diff_w = {hi_s[IW-1], hi_s} - {lo_s[IW-1], lo_s};
    if (int'(in_interval_count) > MAX_INTERVALS) begin
      n_cl = cdi_pkg::CNT_W'(MAX_INTERVALS);
    end else begin
      n_cl = in_interval_count;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r   <= in_opcode;
      lo_r   <= lo_s;
      hi_r   <= hi_s;
      diff_r <= diff_w[IW-1:0];
      zero_r <= (in_interval_count == '0);
      d_r    <= (in_opcode == cdi_pkg::OP_TRAP) ? {1'b0, n_cl} : {n_cl, 1'b0};
    end
  end

  // step divider
  logic [QW-1:0] div_a;
  logic [QW-1:0] quo;
  logic          div_done;
  logic [QW-1:0] q_w;

  logic [55:0] hip_r, lop_r;
  logic [AW-1:0] mag_r;
  logic          neg_r;
  logic          sat_hi_r;

  assign q_w   = QW'({hip_r, 16'b0}) + QW'(lop_r[55:16]);
  assign div_a = QW'(diff_r);

  cdi_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start && !cmd.div_sel_q),
    .dividend (div_a),
    .divisor  (d_r),
    .quotient (quo),
    .done     (div_done)
  );

  always_ff @(posedge clk) begin
    if (cmd.take_step) begin
      step_r <= quo[IW-1:0];
    end
  end

  // sample point generator
  logic [DW-1:0]        k_r;
  logic signed [IW-1:0] x_r;
  logic signed [IW-1:0] x_cur;
  logic [1:0]           w_cur;
  logic                 last_pt;
  logic [IW:0]          x_inc;

  assign last_pt = (k_r == d_r);
  assign x_cur   = last_pt ? hi_r : x_r;
  assign x_inc   = {x_r[IW-1], x_r} + {1'b0, step_r};

  always_comb begin
    if (k_r == '0 || last_pt) begin
      w_cur = 2'd0;
    end else if (op_r == cdi_pkg::OP_TRAP || !k_r[0]) begin
      w_cur = 2'd1;
    end else begin
      w_cur = 2'd2;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_step) begin
      k_r <= '0;
      x_r <= lo_r;
    end else if (cmd.issue) begin
      k_r <= k_r + 1'b1;
      x_r <= x_inc[IW-1:0];
    end
  end

  // cubic pipeline
  logic                 v1_r, v2_r, v3_r;
  logic signed [IW-1:0] x1_r, x2_r, x3_r;
  logic [1:0]           w1_r, w2_r, w3_r;
  logic [30:0]          sq2_r, sq3_r;
  logic signed [55:0]   p3_r;
  logic signed [AW-1:0] acc_r;

  logic signed [47:0] sq_prod;
  logic signed [55:0] cu_prod;
  logic signed [55:0] cu_adj;
  logic signed [FW-1:0] f_w;
  logic [32:0]          sq3x;
  logic signed [AW-1:0] wf;

  assign sq_prod = x1_r * x1_r;
  assign cu_prod = $signed({1'b0, sq2_r}) * x2_r;
  assign cu_adj  = p3_r + (p3_r[55] ? 56'sd65535 : 56'sd0);
  assign sq3x    = {2'b0, sq3_r} + {1'b0, sq3_r, 1'b0};
  assign f_w     = $signed({{2{cu_adj[55]}}, cu_adj[55:16]})
                 - $signed({9'b0, sq3x})
                 - $signed({{(FW-IW){x3_r[IW-1]}}, x3_r})
                 + FW'(589824);
  assign wf      = $signed({{(AW-FW){f_w[FW-1]}}, f_w}) <<< w3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= cmd.issue;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    x1_r  <= x_cur;
    w1_r  <= w_cur;
    x2_r  <= x1_r;
    w2_r  <= w1_r;
    sq2_r <= sq_prod[46:16];
    x3_r  <= x2_r;
    w3_r  <= w2_r;
    sq3_r <= sq2_r;
    p3_r  <= cu_prod;
    if (cmd.take_step) begin
      acc_r <= '0;
    end else if (v3_r) begin
      acc_r <= acc_r + wf;
    end
  end

  // scaling by step
  always_ff @(posedge clk) begin
    if (cmd.take_mag) begin
      neg_r <= acc_r[AW-1];
      mag_r <= acc_r[AW-1] ? AW'(-acc_r) : AW'(acc_r);
    end
    if (cmd.mul_hi) begin
      hip_r <= mag_r[63:32] * step_r;
    end
    if (cmd.mul_lo) begin
      lop_r <= mag_r[31:0] * step_r;
    end
    if (cmd.div_start && cmd.div_sel_q) begin
      sat_hi_r <= (hip_r > 56'd1099511627776);
    end
  end

  // divide by 3, 15 bits a cycle by reciprocal multiply; halving is a shift
  localparam int CH_W = 15;
  localparam int QS_W = 4 * CH_W;
  localparam logic [CH_W+1:0] RECIP3 = 17'd43691;
  localparam logic [1:0]      QCNT_LAST = 2'd3;

  logic [QS_W-1:0]   qs_r;
  logic [1:0]        rem3_r;
  logic [1:0]        qcnt_r;
  logic              qbusy_r;
  logic              qdone_r;
  logic [CH_W+1:0]   qv;
  logic [2*CH_W+3:0] qm;
  logic [CH_W-1:0]   qd;
  logic [CH_W+1:0]   q3;
  logic [1:0]        qrem;
  logic [QW-1:0]     qres;

  assign qv   = {rem3_r, qs_r[QS_W-1 -: CH_W]};
  assign qm   = qv * RECIP3;
  assign qd   = qm[CH_W+16:17];
  assign q3   = {2'b0, qd} + {1'b0, qd, 1'b0};
  assign qrem = qv[1:0] - q3[1:0];
  assign qres = (op_r == cdi_pkg::OP_TRAP) ? {1'b0, q_w[QW-1:1]} : qs_r[QW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qbusy_r <= 1'b0;
      qdone_r <= 1'b0;
      qcnt_r  <= '0;
    end else begin
      qdone_r <= 1'b0;
      if (cmd.div_start && cmd.div_sel_q) begin
        qbusy_r <= 1'b1;
        qcnt_r  <= '0;
      end else if (qbusy_r) begin
        qcnt_r <= qcnt_r + 1'b1;
        if (qcnt_r == QCNT_LAST) begin
          qbusy_r <= 1'b0;
          qdone_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start && cmd.div_sel_q) begin
      qs_r   <= QS_W'(q_w);
      rem3_r <= '0;
    end else if (qbusy_r) begin
      qs_r   <= {qs_r[QS_W-CH_W-1:0], qd};
      rem3_r <= qrem;
    end
  end

  // result
  logic                 sat_w;
  logic [OW-1:0]        val_w;
  logic [cdi_pkg::ST_W-1:0] st_w;
  logic                 out_valid_r;
  logic [OW-1:0]        val_r;
  logic [cdi_pkg::ST_W-1:0] st_r;

  always_comb begin
    if (neg_r) begin
      sat_w = sat_hi_r || (qres > QW'(cdi_pkg::VAL_MIN));
    end else begin
      sat_w = sat_hi_r || (qres > QW'(cdi_pkg::VAL_MAX));
    end
    if (zero_r) begin
      val_w = '0;
      st_w  = cdi_pkg::STATUS_ZERO;
    end else if (sat_w) begin
      val_w = neg_r ? cdi_pkg::VAL_MIN : cdi_pkg::VAL_MAX;
      st_w  = cdi_pkg::STATUS_SAT;
    end else begin
      val_w = neg_r ? OW'(-qres[OW-1:0]) : qres[OW-1:0];
      st_w  = cdi_pkg::STATUS_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      val_r <= val_w;
      st_r  <= st_w;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_integral_value = $signed(val_r);
  assign out_status         = st_r;

  assign sts.cnt_zero   = zero_r;
  assign sts.div_done   = div_done || qdone_r;
  assign sts.last_point = last_pt;
  assign sts.pipe_empty = !(v1_r || v2_r || v3_r);
  assign sts.out_free   = !out_valid_r || !out_stall;

endmodule
`default_nettype wire

[tb/sv/testbench.sv]
`timescale 1ns / 1ps
`default_nettype none
module testbench;
  localparam int IN_W  = cdi_pkg::IN_W;
  localparam int CNT_W = cdi_pkg::CNT_W;
  localparam int OUT_W = cdi_pkg::OUT_W;
  localparam int ST_W  = cdi_pkg::ST_W;

  typedef struct {
    logic                    opcode;
    logic signed [IN_W-1:0]  lower_bound;
    logic signed [IN_W-1:0]  upper_bound;
    logic [CNT_W-1:0]        interval_count;
    bit                      drain;
  } request_t;

  typedef struct {
    logic signed [OUT_W-1:0] integral_value;
    logic [ST_W-1:0]         status;
  } integral_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_opcode = 1'b0;
  logic signed [IN_W-1:0] in_lower_bound = '0;
  logic signed [IN_W-1:0] in_upper_bound = '0;
  logic [CNT_W-1:0] in_interval_count = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [OUT_W-1:0] out_integral_value;
  logic [ST_W-1:0] out_status;

  request_t  pending_requests[$];
  integral_t expected_integrals[$];
  int  mismatch_count = 0;
  bit  stimulus_done = 1'b0;
  int  send_gap = 0;
  int  stall_left = 0;

  cubic_definite_integrator_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_opcode(in_opcode),
    .in_lower_bound(in_lower_bound), .in_upper_bound(in_upper_bound),
    .in_interval_count(in_interval_count),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_integral_value(out_integral_value), .out_status(out_status)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic longint cubic_q16(longint x);
    longint sq, cu;
    sq = longint'(64'(x * x) >> 16);
    cu = (sq * x) / 65536;
    return cu - 3 * sq - x + 9 * 65536;
  endfunction

  function automatic integral_t integrate(request_t rq);
    integral_t res;
    longint lo, hi, t, sum, xk;
    longint unsigned d, c, step, mag, mh, ml, hiprod, q, r, n;
    bit neg, sat;
    sat = 1'b0;
    r = 0;
    if (rq.interval_count == 0) begin
      res.integral_value = '0;
      res.status = cdi_pkg::STATUS_ZERO;
      return res;
    end
    n = rq.interval_count;
    lo = rq.lower_bound;
    hi = rq.upper_bound;
    if (hi < lo) begin
      t = lo; lo = hi; hi = t;
    end
    d = (rq.opcode == cdi_pkg::OP_TRAP) ? n : 2 * n;
    c = (rq.opcode == cdi_pkg::OP_TRAP) ? 2 : 3;
    step = longint'(hi - lo) / d;
    sum = cubic_q16(lo) + cubic_q16(hi);
    for (longint unsigned k = 1; k < d; k++) begin
      xk = lo + longint'(k * step);
      if (rq.opcode == cdi_pkg::OP_TRAP || !k[0]) sum += 2 * cubic_q16(xk);
      else sum += 4 * cubic_q16(xk);
    end
    neg = sum < 0;
    mag = neg ? -sum : sum;
    mh = mag >> 32;
    ml = mag & 64'hFFFF_FFFF;
    hiprod = mh * step;
    if (hiprod > (64'd1 << 40)) sat = 1'b1;
    else begin
      q = (hiprod << 16) + ((ml * step) >> 16);
      r = q / c;
      if (neg ? (r > 64'h8000_0000_0000) : (r > 64'h7FFF_FFFF_FFFF)) sat = 1'b1;
    end
    if (sat) res.integral_value = neg ? cdi_pkg::VAL_MIN : cdi_pkg::VAL_MAX;
    else res.integral_value = neg ? -r[OUT_W-1:0] : r[OUT_W-1:0];
    res.status = sat ? cdi_pkg::STATUS_SAT : cdi_pkg::STATUS_OK;
    return res;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    mismatch_count++;
  endtask

  function automatic int random_gap();
    if ($urandom_range(0, 3) == 0) return 0;
    return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 3);
  endfunction

  function automatic logic signed [IN_W-1:0] random_bound();
    case ($urandom_range(0, 3))
      0: return IN_W'($urandom);
      1: return IN_W'($urandom_range(0, 8 * 65536)) - IN_W'(4 * 65536);
      2: return ($urandom_range(0, 1)) ? 24'h7FFFFF : 24'h800000;
      default: return IN_W'($urandom_range(0, 2 * 65536));
    endcase
  endfunction

  task automatic add_request(logic op, logic signed [IN_W-1:0] lo,
                             logic signed [IN_W-1:0] hi, logic [CNT_W-1:0] n,
                             bit drain = 1'b0);
    request_t rq;
    rq.opcode = op; rq.lower_bound = lo; rq.upper_bound = hi;
    rq.interval_count = n; rq.drain = drain;
    pending_requests.push_back(rq);
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && in_stall) begin
    end else begin
      if (in_valid) begin
        expected_integrals.push_back(integrate('{in_opcode, in_lower_bound,
                                                 in_upper_bound, in_interval_count, 1'b0}));
      end
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        in_valid <= 1'b0;
      end else if (pending_requests.size() > 0 &&
                   !(pending_requests[0].drain &&
                     (expected_integrals.size() > 0 || in_valid))) begin
        request_t rq;
        rq = pending_requests.pop_front();
        in_valid <= 1'b1;
        in_opcode <= rq.opcode;
        in_lower_bound <= rq.lower_bound;
        in_upper_bound <= rq.upper_bound;
        in_interval_count <= rq.interval_count;
        send_gap <= random_gap();
      end else begin
        in_valid <= 1'b0;
        if (pending_requests.size() == 0 && !in_valid) stimulus_done <= 1'b1;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_integrals.size() == 0) begin
          report_mismatch("unexpected word", out_integral_value, 0);
        end else begin
          integral_t want;
          want = expected_integrals.pop_front();
          if (out_integral_value !== want.integral_value)
            report_mismatch("integral_value", out_integral_value, want.integral_value);
          if (out_status !== want.status)
            report_mismatch("status", out_status, want.status);
        end
      end
      if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
        stall_left <= random_gap();
      end
    end
  end

  initial begin
    // directed: extremes, both rules, reversed bounds, zero count, tiny ranges
    add_request(cdi_pkg::OP_SIMPSON, 24'sh000000, 24'sh020000, 16'd4);
    add_request(cdi_pkg::OP_TRAP,    24'sh000000, 24'sh020000, 16'd4);
    add_request(cdi_pkg::OP_SIMPSON, 24'sh020000, 24'sh000000, 16'd3);
    add_request(cdi_pkg::OP_TRAP,    24'sh030000, 24'shFF0000, 16'd5);
    add_request(cdi_pkg::OP_SIMPSON, 24'sh010000, 24'sh050000, 16'd0);
    add_request(cdi_pkg::OP_TRAP,    24'sh010000, 24'sh050000, 16'd0);
    add_request(cdi_pkg::OP_SIMPSON, 24'sh123456, 24'sh123456, 16'd7);
    add_request(cdi_pkg::OP_TRAP,    24'sh000000, 24'sh000003, 16'd8);
    add_request(cdi_pkg::OP_SIMPSON, 24'sh800000, 24'sh7FFFFF, 16'd1);
    add_request(cdi_pkg::OP_TRAP,    24'sh800000, 24'sh7FFFFF, 16'd1);
    add_request(cdi_pkg::OP_SIMPSON, 24'sh7FFFFF, 24'sh800000, 16'd2);
    add_request(cdi_pkg::OP_TRAP,    24'sh800000, 24'sh000000, 16'd3);
    add_request(cdi_pkg::OP_SIMPSON, 24'sh000000, 24'sh7FFFFF, 16'd6);
    add_request(cdi_pkg::OP_TRAP,    24'shFFFFFF, 24'sh000001, 16'd1);
    add_request(cdi_pkg::OP_SIMPSON, 24'shFF0000, 24'sh030000, 16'hFFFF, 1'b1);
    add_request(cdi_pkg::OP_TRAP,    24'sh800000, 24'sh7FFFFF, 16'hFFFF);
    add_request(cdi_pkg::OP_SIMPSON, 24'sh555555, 24'shAAAAAA, 16'h8000);
    add_request(cdi_pkg::OP_TRAP,    24'shAAAAAA, 24'sh555555, 16'h7FFF);
    for (int i = 0; i < 82; i++) begin
      logic [CNT_W-1:0] n;
      case ($urandom_range(0, 19))
        0: n = 16'd0;
        1: n = CNT_W'($urandom);
        default: n = CNT_W'($urandom_range(1, 40));
      endcase
      add_request(1'($urandom), random_bound(), random_bound(), n, i == 40);
    end
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    wait (stimulus_done && expected_integrals.size() == 0);
    repeat (200) @(posedge clk);
    if (mismatch_count == 0) $display("testbench: PASS");
    else $display("testbench: FAIL");
    $finish;
  end

  initial begin
    #1s;
    $display("testbench: FAIL");
    $finish;
  end
endmodule
`default_nettype wire
